// ===== rtl/esd_pkg.sv =====
// Package for the escape sequence decoder: decode modes, the queued run
// record, queue status, character codes and the hex and octal digit helpers.
// No dependencies.
package esd_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_BS   = 3'd1,
        MODE_HEX1 = 3'd2,
        MODE_HEX2 = 3'd3,
        MODE_OCT  = 3'd4
    } mode_t;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;

    // Marks a byte that is not a hex digit (value 16)
    localparam logic [4:0] HEX_NONE  = 5'd16;

    // One decoded run: up to three result bytes caused by a single input
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0][7:0] data;
        logic            mark_valid;
        logic            buf_end;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= CH_0 && c <= CH_9) begin
            v = 5'(c - CH_0);
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = 5'(c - CH_LA + 8'd10);
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = 5'(c - CH_UA + 8'd10);
        end else begin
            v = HEX_NONE;
        end
        return v;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

endpackage

// ===== rtl/esd_front.sv =====
// Front end of the escape sequence decoder: accepts raw bytes, tracks the
// escape state and classifies each byte into a run of results.
// Depends on esd_pkg.
module esd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] in_byte
    input  logic               s_tlast,   // buffer_end
    input  esd_pkg::q_status_t q_stat,
    output logic               push,
    output esd_pkg::run_t      entry
);

    esd_pkg::mode_t mode_reg, mode_next;
    logic [7:0]     held_hex_reg, held_hex_next;
    logic [2:0]     held_oct_reg, held_oct_next;
    logic           accept;
    logic [4:0]     v1, v2;
    logic [7:0]     b;
    logic           e;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign e        = s_tlast;
    assign v1       = esd_pkg::hex_value(held_hex_reg);
    assign v2       = esd_pkg::hex_value(b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= esd_pkg::MODE_IDLE;
            held_hex_reg <= 8'd0;
            held_oct_reg <= 3'd0;
        end else if (accept) begin
            mode_reg     <= mode_next;
            held_hex_reg <= held_hex_next;
            held_oct_reg <= held_oct_next;
        end
    end

    always_comb begin
        mode_next        = esd_pkg::MODE_IDLE;
        held_hex_next    = held_hex_reg;
        held_oct_next    = held_oct_reg;
        entry            = '0;
        entry.mark_valid = 1'b1;
        entry.buf_end    = e;

        unique case (mode_reg)
            esd_pkg::MODE_BS: begin
                if (b == esd_pkg::CH_X) begin
                    if (e) begin
                        entry.count   = 2'd2;
                        entry.data[0] = esd_pkg::CH_BSLASH;
                        entry.data[1] = esd_pkg::CH_X;
                    end else begin
                        mode_next = esd_pkg::MODE_HEX1;
                    end
                end else if (b == esd_pkg::CH_V) begin
                    entry.count = 2'd0;
                end else if (esd_pkg::is_octal(b)) begin
                    if (e) begin
                        entry.count   = 2'd1;
                        entry.data[0] = {5'd0, b[2:0]};
                    end else begin
                        held_oct_next = b[2:0];
                        mode_next     = esd_pkg::MODE_OCT;
                    end
                end else begin
                    entry.count   = 2'd2;
                    entry.data[0] = esd_pkg::CH_BSLASH;
                    entry.data[1] = b;
                end
            end
            esd_pkg::MODE_HEX1: begin
                if (e) begin
                    entry.count   = 2'd3;
                    entry.data[0] = esd_pkg::CH_BSLASH;
                    entry.data[1] = esd_pkg::CH_X;
                    entry.data[2] = b;
                end else begin
                    held_hex_next = b;
                    mode_next     = esd_pkg::MODE_HEX2;
                end
            end
            esd_pkg::MODE_HEX2: begin
                entry.count = 2'd1;
                if (v1 == esd_pkg::HEX_NONE) begin
                    entry.data[0] = 8'd0;
                end else if (v2 == esd_pkg::HEX_NONE) begin
                    entry.data[0] = {4'd0, v1[3:0]};
                end else begin
                    entry.data[0] = {v1[3:0], v2[3:0]};
                end
            end
            esd_pkg::MODE_OCT: begin
                if (esd_pkg::is_octal(b)) begin
                    entry.count   = 2'd1;
                    entry.data[0] = {2'd0, held_oct_reg, b[2:0]};
                end else begin
                    // held digit goes out first, then the byte as if idle
                    entry.data[0] = {5'd0, held_oct_reg};
                    if (b == esd_pkg::CH_BSLASH && !e) begin
                        entry.count = 2'd1;
                        mode_next   = esd_pkg::MODE_BS;
                    end else begin
                        entry.count   = 2'd2;
                        entry.data[1] = b;
                    end
                end
            end
            default: begin
                if (b == esd_pkg::CH_BSLASH && !e) begin
                    mode_next = esd_pkg::MODE_BS;
                end else begin
                    entry.count   = 2'd1;
                    entry.data[0] = b;
                end
            end
        endcase

        if (e) begin
            mode_next = esd_pkg::MODE_IDLE;
            // buffer end with nothing to show: bare end marker
            if (entry.count == 2'd0) begin
                entry.count      = 2'd1;
                entry.data       = '0;
                entry.mark_valid = 1'b0;
            end
        end
    end

    assign push = accept && (entry.count != 2'd0);

`ifndef ASSERT_OFF
    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> mode_reg == esd_pkg::MODE_IDLE)
        else $error("mode not idle after buffer end");
`endif

endmodule

// ===== rtl/esd_queue.sv =====
// Short run queue between the decoder front end and the output sequencer.
// Depends on esd_pkg.
module esd_queue #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  esd_pkg::run_t      wdata,
    input  logic               pop,
    output esd_pkg::run_t      rdata,
    output esd_pkg::q_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    esd_pkg::run_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign rdata        = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/esd_back.sv =====
// Output sequencer: takes runs from the queue and emits their results one
// transfer at a time. Depends on esd_pkg.
module esd_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  esd_pkg::run_t      rdata,
    input  esd_pkg::q_status_t q_stat,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] out_byte
    output logic [1:0]         m_tuser,   // [0] byte_valid, [1] decoded_end
    output logic               m_tlast    // run_last
);

    esd_pkg::run_t cur_reg;
    logic          busy_reg, busy_next;
    logic [1:0]    idx_reg, idx_next;
    logic          advance, last, done, load;

    assign last    = (idx_reg == cur_reg.count - 2'd1);
    assign advance = busy_reg && m_tready;
    assign done    = advance && last;
    assign load    = (!busy_reg || done) && !q_stat.empty;
    assign pop     = load;

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load) begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (advance) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            cur_reg <= rdata;
        end
    end

    always_comb begin
        case (idx_reg)
            2'd0:    m_tdata = cur_reg.data[0];
            2'd1:    m_tdata = cur_reg.data[1];
            default: m_tdata = cur_reg.data[2];
        endcase
    end

    assign m_tvalid   = busy_reg;
    assign m_tlast    = last;
    assign m_tuser[0] = cur_reg.mark_valid;
    assign m_tuser[1] = last && cur_reg.buf_end;

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(idx_reg))
        else $error("result index moved while stalled");
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> idx_reg < cur_reg.count)
        else $error("result index past run length");
`endif

endmodule

// ===== rtl/escape_sequence_decoder.sv =====
// Top level of the backslash escape decoder: front end, run queue and
// output sequencer. Depends on esd_pkg, esd_front, esd_queue, esd_back.
//
//  channel | dir | tdata        | tuser                         | tlast
//  s_      | in  | [7:0] byte   | -                             | buffer end
//  m_      | out | [7:0] byte   | [0] byte_valid [1] decoded_end | run last
//
// One input byte is taken per cycle while the run queue has room.
// A byte that decodes to n results yields n transfers, and results go out at
// one per cycle while m_tready is high; escape prefixes give none.
// Each result passes through the queue, then the output register.
// Reset (aresetn low, synchronous) returns the decoder to idle and empties
// the queue. Output stalls back up into the queue, then into s_tready.
module escape_sequence_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,    // buffer_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [1:0] m_tuser,    // [0] byte_valid, [1] decoded_end
    output logic       m_tlast     // run_last
);

    esd_pkg::q_status_t q_stat;
    esd_pkg::run_t      wr_entry, rd_entry;
    logic               push, pop;

    esd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (push),
        .entry    (wr_entry)
    );

    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .wdata   (wr_entry),
        .pop     (pop),
        .rdata   (rd_entry),
        .status  (q_stat)
    );

    esd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rdata    (rd_entry),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
